@@ design/pwm_encoder_position_filter_defines.svh @@
// Assertion macros for the PWM encoder position filter.
// Included by the top level; no other dependencies.
`ifndef PWM_ENCODER_POSITION_FILTER_DEFINES_SVH
`define PWM_ENCODER_POSITION_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PWMEF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwmef same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PWMEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwmef next-cycle check failed");

`endif

@@ design/pwmef_pkg.sv @@
// Shared types and constants for the PWM encoder position filter.
// No dependencies.
package pwmef_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RATIO_GO,
    S_RATIO,
    S_PUSH,
    S_BAND,
    S_COMP
  } state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [2:0] CFG_PERIOD_LOW      = 3'd0;
  localparam logic [2:0] CFG_PERIOD_HIGH     = 3'd1;
  localparam logic [2:0] CFG_BAND_HALF_WIDTH = 3'd2;
  localparam logic [2:0] CFG_DIRECTION       = 3'd3;
  localparam logic [2:0] CFG_ZERO_OFFSET     = 3'd4;

  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_CW   = 2'b01;
  localparam logic [1:0] DIR_CCW  = 2'b11;

  localparam logic [31:0] PERIOD_LOW_RST  = 32'd56000;
  localparam logic [31:0] PERIOD_HIGH_RST = 32'd76000;
  localparam logic [15:0] BAND_HW_RST     = 16'd128;

  localparam logic signed [5:0] QUAL_RST = -6'sd15;
  localparam logic signed [5:0] QUAL_MIN = -6'sd16;
  localparam logic signed [5:0] QUAL_MAX = 6'sd16;

endpackage

@@ design/pwmef_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwmef_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/pwmef_div.sv @@
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// Depends on pwmef_pkg (div_status_t).
module pwmef_div import pwmef_pkg::*; #(
  parameter int DIVIDEND_W = 44
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [31:0]           divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output div_status_t           status
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic [31:0]   rem;
  logic [CW-1:0] cnt;
  logic [32:0]   shifted;
  logic [32:0]   diff;
  logic          ge;

  assign shifted = {rem, quotient[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign ge      = !diff[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      // done pulses for one cycle after the last iteration
      status.done <= !start && status.busy && (cnt == CW'(1));
      if (start) begin
        status.busy <= 1'b1;
        cnt         <= CW'(DIVIDEND_W);
      end else if (status.busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          status.busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (status.busy) begin
      rem      <= ge ? diff[31:0] : shifted[31:0];
      quotient <= {quotient[DIVIDEND_W-2:0], ge};
    end
  end

endmodule

@@ design/pwm_encoder_position_filter.sv @@
// Top level of the PWM absolute encoder position filter.
// Depends on pwmef_pkg, pwmef_div, pwmef_ram and the assertion macro header.
//
// Usage:
//  - Input channel (in_valid/in_ready): opcode 0 is an edge transaction
//    (timestamp, level); opcode 1 is a position read. Edge transactions are
//    absorbed in the accept cycle and give no result.
//  - Output channel (out_valid/out_ready): one result per read.
//  - cfg_we/cfg_index/cfg_data write the five registers; write only while idle.
//  - A read whose period passes the gate runs the restoring divider
//    once for on_time * 2^RATIO_SHIFT / period: the start state,
//    32 + RATIO_SHIFT iterations and the done pulse, then an optional
//    store write, the band update and the output load. A zero ratio skips
//    the store write and the band update. The next transaction is taken
//    once the sequencer is back in idle.
//  - A gated read goes from the accept straight to the output load.
//    Edge transactions leave the sequencer idle.
//  - in_ready is high only while the sequencer is idle.
//  - The result sits in an output register; the block goes idle and takes
//    new transactions while it waits. A following read stalls in its final
//    step until the previous result is taken.
//  - Reset (rst, synchronous) restores register defaults, clears the
//    average store valid bits and sum, and sets the quality count to -15.
`include "pwm_encoder_position_filter_defines.svh"

module pwm_encoder_position_filter import pwmef_pkg::*; #(
  parameter int STORE_DEPTH  = 16,
  parameter int WARMUP_LEVEL = 8,
  parameter int RATIO_SHIFT  = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [31:0]        timestamp,
  input  logic               level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        position,
  output logic [15:0]        previous_position,
  output logic               fresh,
  output logic [15:0]        filtered_raw,
  output logic signed [5:0]  quality,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int PTR_W = $clog2(STORE_DEPTH);
  localparam int SUM_W = 16 + PTR_W;
  localparam int DIV_W = 32 + RATIO_SHIFT;
  localparam logic signed [5:0] WARMUP_Q = 6'(WARMUP_LEVEL);

  // mean = (sum * ceil(2^MEAN_K / depth)) >> MEAN_K, exact for any sum below 2^SUM_W
  localparam int MEAN_K  = SUM_W + PTR_W;
  localparam int RECIP_W = MEAN_K + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'(((64'd1 << MEAN_K) + 64'(STORE_DEPTH) - 64'd1) / 64'(STORE_DEPTH));

  // configuration registers
  logic [31:0]        period_low;
  logic [31:0]        period_high;
  logic [15:0]        band_half_width;
  logic [1:0]         direction;
  logic signed [12:0] zero_offset;

  // measurement and filter state
  logic [31:0]        on_time;
  logic [31:0]        period;
  logic [31:0]        last_rise_time;
  logic               fresh_flag;
  logic [PTR_W-1:0]   store_pointer;
  logic [STORE_DEPTH-1:0] store_valid;
  logic [SUM_W-1:0]   store_sum;
  logic signed [5:0]  quality_count;
  logic [15:0]        last_good;
  logic [15:0]        band_low;
  logic [15:0]        band_high;
  logic [15:0]        raw_position;
  logic [15:0]        output_position;

  state_t state, state_next;

  // sequencer strobes
  logic div_start;
  logic ram_we;
  logic load_out;
  logic in_accept;

  logic [DIV_W-1:0] div_dividend;
  logic [31:0]      div_divisor;
  logic [DIV_W-1:0] div_quo;
  div_status_t      div_stat;
  logic [15:0]      ram_rdata;

  logic [15:0] ratio;
  logic        ratio_zero;
  logic        in_band;
  logic        warming;
  logic        do_push;
  logic [15:0] old_sample;
  logic [PROD_W-1:0] mean_prod;
  logic [15:0] mean;
  logic [31:0] delta;
  logic [12:0] off_neg;
  logic [11:0] off_mag;
  logic [11:0] dir_pos;
  logic [15:0] pos_next;

  assign in_accept = in_valid && in_ready;

  // ---- divider: duty ratio ----
  assign div_dividend = {on_time, {RATIO_SHIFT{1'b0}}};
  assign div_divisor  = period;

  pwmef_div #(.DIVIDEND_W(DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .status   (div_stat)
  );

  // ---- moving-average store; read port follows the write pointer ----
  pwmef_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (store_pointer),
    .wdata (raw_position),
    .raddr (store_pointer),
    .rdata (ram_rdata)
  );

  // entries never written read as zero
  assign old_sample = store_valid[store_pointer] ? ram_rdata : 16'd0;

  // store mean from the running sum
  assign mean_prod = PROD_W'(store_sum) * PROD_W'(MEAN_RECIP);
  assign mean      = mean_prod[MEAN_K +: 16];

  // ---- filter decision on the fresh ratio ----
  assign ratio      = div_quo[15:0];
  assign ratio_zero = (ratio == 16'd0);
  assign warming    = (quality_count < WARMUP_Q);
  assign in_band    = (ratio > band_low) && (ratio < band_high);
  assign do_push    = warming || in_band;

  // ---- edge delta ----
  assign delta = timestamp - last_rise_time;

  // ---- direction and offset compensation ----
  assign off_neg = -zero_offset;
  assign off_mag = zero_offset[12] ? off_neg[11:0] : zero_offset[11:0];
  assign dir_pos = (direction == DIR_CCW) ? (12'd0 - raw_position[11:0])
                                          : raw_position[11:0];

  always_comb begin
    case (direction)
      DIR_CW, DIR_CCW: pos_next = {4'd0, dir_pos - off_mag};
      DIR_NONE:        pos_next = raw_position;
      default:         pos_next = output_position;  // meaningless code: hold
    endcase
  end

  // ---- sequencer: next state ----
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_accept && opcode == OP_READ) begin
          state_next = (period > period_low) ? S_RATIO_GO : S_COMP;
        end
      end
      S_RATIO_GO: state_next = S_RATIO;
      S_RATIO: begin
        if (div_stat.done) begin
          if (ratio_zero) begin
            state_next = S_COMP;
          end else if (do_push) begin
            state_next = S_PUSH;
          end else begin
            state_next = S_BAND;
          end
        end
      end
      S_PUSH: state_next = S_BAND;
      S_BAND: state_next = S_COMP;
      S_COMP: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---- sequencer: strobes ----
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    load_out  = 1'b0;
    case (state)
      S_IDLE:     in_ready  = 1'b1;
      S_RATIO_GO: div_start = 1'b1;
      S_PUSH:     ram_we    = 1'b1;
      S_COMP:     load_out  = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      period_low      <= PERIOD_LOW_RST;
      period_high     <= PERIOD_HIGH_RST;
      band_half_width <= BAND_HW_RST;
      direction       <= DIR_NONE;
      zero_offset     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD_LOW:      period_low      <= cfg_data;
        CFG_PERIOD_HIGH:     period_high     <= cfg_data;
        CFG_BAND_HALF_WIDTH: band_half_width <= cfg_data[15:0];
        CFG_DIRECTION:       direction       <= cfg_data[1:0];
        CFG_ZERO_OFFSET:     zero_offset     <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  // ---- edge capture and filter state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      on_time         <= '0;
      period          <= '0;
      last_rise_time  <= '0;
      fresh_flag      <= 1'b0;
      store_pointer   <= '0;
      store_valid     <= '0;
      store_sum       <= '0;
      quality_count   <= QUAL_RST;
      last_good       <= '0;
      band_low        <= '0;
      band_high       <= '0;
      raw_position    <= '0;
      output_position <= '0;
    end else begin
      if (in_accept && opcode == OP_EDGE) begin
        if (level) begin
          if (delta < period_high && delta > period_low) begin
            period <= delta;
          end
          last_rise_time <= timestamp;
        end else begin
          on_time <= delta;
        end
        fresh_flag <= 1'b1;
      end

      if (state == S_RATIO && div_stat.done) begin
        if (ratio_zero) begin
          raw_position <= 16'd0;
        end else if (warming) begin
          raw_position <= ratio;
        end else if (in_band) begin
          raw_position <= ratio;
          last_good    <= ratio;
        end else begin
          raw_position <= last_good;
          if (quality_count > QUAL_MIN) begin
            quality_count <= quality_count - 6'sd1;
          end
        end
      end

      // replace oldest sample, keep running sum
      if (ram_we) begin
        store_sum <= store_sum - SUM_W'(old_sample) + SUM_W'(raw_position);
        store_valid[store_pointer] <= 1'b1;
        store_pointer <= (store_pointer == PTR_W'(STORE_DEPTH - 1))
                         ? '0 : store_pointer + PTR_W'(1);
        if (quality_count < QUAL_MAX) begin
          quality_count <= quality_count + 6'sd1;
        end
      end

      // outlier band round the updated mean, wrapping at 16 bits
      if (state == S_BAND) begin
        band_low  <= mean - band_half_width;
        band_high <= mean + band_half_width;
      end

      if (load_out) begin
        output_position <= pos_next;
        fresh_flag      <= 1'b0;
      end
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      position          <= pos_next;
      previous_position <= output_position;
      fresh             <= fresh_flag;
      filtered_raw      <= raw_position;
      quality           <= quality_count;
    end
  end

  // ---- assertions ----
  `PWMEF_ASSERT_NOW(a_quality_range, clk, rst, 1'b1,
    quality_count >= QUAL_MIN && quality_count <= QUAL_MAX)
  `PWMEF_ASSERT_NOW(a_div_done_state, clk, rst, div_stat.done, state == S_RATIO)
  `PWMEF_ASSERT_NEXT(a_read_blocks, clk, rst, in_accept && opcode == OP_READ,
    !in_ready)
  `PWMEF_ASSERT_NEXT(a_fresh_cleared, clk, rst, load_out, !fresh_flag && out_valid)

endmodule
